// ===== rtl/dss_pkg.sv =====
// Types, codes and constants shared by the dual stack blocks.
package dss_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int OCC_W     = 7;

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               command;
		logic                     stack_select;
		logic signed [DATA_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] pop_value;
		logic [OCC_W-1:0]         occupancy;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic load;
	} ctrl_cmd_t;

endpackage

// ===== rtl/dss_chan_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
interface dss_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dss_ctrl.sv =====
// Controller state machine for request acceptance and result hand-off.
module dss_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dss_pkg::ctrl_cmd_t cmd
);
	import dss_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		cmd.accept = 1'b0;
		cmd.load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_DONE)
		else $error("accepted item did not move to result stage");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> out_valid_q)
		else $error("loaded result not presented");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> state_q == ST_IDLE)
		else $error("request taken outside idle state");

endmodule

// ===== rtl/dss_dpath.sv =====
// Datapath: stack counts, shared entry memory and result register.
module dss_dpath #(
	parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dss_pkg::ctrl_cmd_t cmd,
	input  dss_pkg::req_t      req,
	output dss_pkg::rsp_t      rsp
);
	import dss_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [CW-1:0]     lower_q;
	logic [CW-1:0]     upper_q;
	logic [1:0]        status_q;
	logic              pop_ok_q;
	logic [DATA_W-1:0] rdata_q;
	rsp_t              rsp_q;
	logic [DATA_W-1:0] mem [DEPTH];

	logic [CW-1:0]     sum;
	logic              full;
	logic [CW-1:0]     lower_d;
	logic [CW-1:0]     upper_d;
	logic [1:0]        status_d;
	logic              wr_en;
	logic              rd_en;
	logic [CW-1:0]     addr_w;
	logic [AW-1:0]     addr;

	assign sum  = lower_q + upper_q;
	assign full = (sum == CW'(DEPTH));
	assign addr = addr_w[AW-1:0];

	always_comb begin
		lower_d  = lower_q;
		upper_d  = upper_q;
		status_d = STAT_OK;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		addr_w   = lower_q;
		case (req.command)
			CMD_PUSH: begin
				if (full) begin
					status_d = STAT_FULL;
				end else if (!req.stack_select) begin
					wr_en   = 1'b1;
					addr_w  = lower_q;
					lower_d = lower_q + 1'b1;
				end else begin
					wr_en   = 1'b1;
					addr_w  = CW'(DEPTH - 1) - upper_q;
					upper_d = upper_q + 1'b1;
				end
			end
			CMD_POP: begin
				if (!req.stack_select) begin
					if (lower_q == '0) begin
						status_d = STAT_EMPTY;
					end else begin
						rd_en   = 1'b1;
						addr_w  = lower_q - 1'b1;
						lower_d = lower_q - 1'b1;
					end
				end else begin
					if (upper_q == '0) begin
						status_d = STAT_EMPTY;
					end else begin
						rd_en   = 1'b1;
						addr_w  = CW'(DEPTH) - upper_q;
						upper_d = upper_q - 1'b1;
					end
				end
			end
			CMD_CLEAR: begin
				lower_d = '0;
				upper_d = '0;
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= '0;
			upper_q  <= '0;
			pop_ok_q <= 1'b0;
		end else if (cmd.accept) begin
			lower_q  <= lower_d;
			upper_q  <= upper_d;
			pop_ok_q <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_q <= status_d;
		end
		if (cmd.accept && wr_en) begin
			mem[addr] <= req.push_value;
		end
		if (cmd.accept && rd_en) begin
			rdata_q <= mem[addr];
		end
		if (cmd.load) begin
			rsp_q.status    <= status_q;
			rsp_q.pop_value <= pop_ok_q ? rdata_q : '0;
			rsp_q.occupancy <= OCC_W'(sum);
		end
	end

	assign rsp = rsp_q;

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW + 1)'(lower_q) + (CW + 1)'(upper_q) <= (CW + 1)'(DEPTH))
		else $error("stack counts exceed memory depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && req.command == CMD_CLEAR |=> lower_q == '0 && upper_q == '0)
		else $error("clear left items behind");

	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && req.command == CMD_PUSH && !full |=> sum == $past(sum) + 1'b1)
		else $error("push did not grow occupancy by one");

endmodule

// ===== rtl/dual_stack_shared_array.sv =====
// Top level: two stacks sharing one entry memory.
//
//  channel | dir | payload                                 | accepted when
//  req     | in  | command, stack_select, push_value       | req.valid && req.ready
//  rsp     | out | status, pop_value, occupancy            | rsp.valid && rsp.ready
//
// An item is accepted in ST_IDLE, which updates counts and drives the memory
// port; ST_DONE loads the registered read data into the result once the output
// register frees. The single memory port and registered read force this split.
// Reset clears both counts and the result valid; the memory is not cleared.
// A new item is taken while an earlier result waits; a stalled result holds
// the following one in the datapath until the output register frees.
module dual_stack_shared_array #(
	parameter int DEPTH = dss_pkg::DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	dss_chan_if.sink   req,
	dss_chan_if.source rsp
);
	import dss_pkg::*;

	ctrl_cmd_t cmd;

	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	dss_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req.data),
		.rsp    (rsp.data)
	);

endmodule

// ===== tb/sv/dual_stack_shared_array_tb.sv =====
// Testbench for the shared-array dual stack: random and directed request traffic with a scoreboard.
module dual_stack_shared_array_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dss_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_GAP = 12;

	logic clk;
	logic arst_n;

	dss_chan_if #(.payload_t(req_t)) req_ch ();
	dss_chan_if #(.payload_t(rsp_t)) rsp_ch ();

	dual_stack_shared_array #(.DEPTH(DEPTH)) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	int unsigned lower_cnt;
	int unsigned upper_cnt;
	logic [DATA_W-1:0] stack_mem [DEPTH];
	rsp_t stack_results_q [$];
	int errors;
	int idle_cycles;
	bit steady;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic rsp_t apply_stack_request(req_t r);
		rsp_t res;
		res.status = STAT_OK;
		res.pop_value = '0;
		case (r.command)
			CMD_PUSH: begin
				if (lower_cnt + upper_cnt >= DEPTH) begin
					res.status = STAT_FULL;
				end else if (r.stack_select == 1'b0) begin
					stack_mem[lower_cnt] = r.push_value;
					lower_cnt++;
				end else begin
					upper_cnt++;
					stack_mem[DEPTH - upper_cnt] = r.push_value;
				end
			end
			CMD_POP: begin
				if (r.stack_select == 1'b0) begin
					if (lower_cnt == 0) begin
						res.status = STAT_EMPTY;
					end else begin
						lower_cnt--;
						res.pop_value = stack_mem[lower_cnt];
					end
				end else begin
					if (upper_cnt == 0) begin
						res.status = STAT_EMPTY;
					end else begin
						res.pop_value = stack_mem[DEPTH - upper_cnt];
						upper_cnt--;
					end
				end
			end
			CMD_CLEAR: begin
				lower_cnt = 0;
				upper_cnt = 0;
			end
			default: ;
		endcase
		res.occupancy = OCC_W'(lower_cnt + upper_cnt);
		return res;
	endfunction

	task automatic send_request(logic [1:0] cmd, logic sel, logic [DATA_W-1:0] val);
		req_t r;
		int gap;
		bit taken;
		r.command = cmd;
		r.stack_select = sel;
		r.push_value = val;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do begin
			@(negedge clk);
			taken = req_ch.ready;
			@(posedge clk);
		end while (!taken);
		stack_results_q.push_back(apply_stack_request(r));
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			int stall;
			bit taken;
			stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				taken = rsp_ch.valid && rsp_ch.ready;
				@(posedge clk);
			end while (!taken);
		end
	end

	always @(negedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			rsp_t want;
			if (stack_results_q.size() == 0) begin
				$error("result with nothing pending: status %0d pop_value %0d occupancy %0d",
					rsp_ch.data.status, rsp_ch.data.pop_value, rsp_ch.data.occupancy);
				errors++;
			end else begin
				want = stack_results_q.pop_front();
				if (rsp_ch.data.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp_ch.data.status);
					errors++;
				end
				if (rsp_ch.data.pop_value !== want.pop_value) begin
					$error("pop_value: expected %0d, actual %0d",
						want.pop_value, rsp_ch.data.pop_value);
					errors++;
				end
				if (rsp_ch.data.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, actual %0d",
						want.occupancy, rsp_ch.data.occupancy);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic test_empty_pops();
		send_request(CMD_POP, 1'b0, $urandom);
		send_request(CMD_POP, 1'b1, $urandom);
	endtask

	task automatic test_extreme_values();
		send_request(CMD_PUSH, 1'b0, 32'h7FFF_FFFF);
		send_request(CMD_PUSH, 1'b0, 32'h8000_0000);
		send_request(CMD_PUSH, 1'b1, 32'h0000_0000);
		send_request(CMD_PUSH, 1'b1, 32'hFFFF_FFFF);
		send_request(CMD_POP, 1'b1, 32'hFFFF_FFFF);
		send_request(CMD_POP, 1'b0, 32'h0000_0000);
		send_request(CMD_POP, 1'b1, $urandom);
		send_request(CMD_POP, 1'b0, $urandom);
		send_request(CMD_POP, 1'b0, $urandom);
	endtask

	task automatic test_unused_code();
		send_request(CMD_PUSH, 1'b1, $urandom);
		send_request(CMD_UNUSED, 1'b0, 32'hFFFF_FFFF);
		send_request(CMD_UNUSED, 1'b1, $urandom);
	endtask

	task automatic test_clear();
		send_request(CMD_PUSH, 1'b0, $urandom);
		send_request(CMD_PUSH, 1'b1, $urandom);
		send_request(CMD_CLEAR, 1'b1, $urandom);
		send_request(CMD_POP, 1'b0, $urandom);
		send_request(CMD_POP, 1'b1, $urandom);
		send_request(CMD_CLEAR, 1'b0, $urandom);
	endtask

	task automatic test_fill_to_full();
		for (int i = 0; i < DEPTH; i++) begin
			send_request(CMD_PUSH, 1'($urandom), $urandom);
		end
		send_request(CMD_PUSH, 1'b0, $urandom);
		send_request(CMD_PUSH, 1'b1, $urandom);
		for (int i = 0; i < DEPTH + 2; i++) begin
			send_request(CMD_POP, 1'(i % 2), $urandom);
		end
		while (lower_cnt + upper_cnt > 0) begin
			send_request(CMD_POP, lower_cnt > 0 ? 1'b0 : 1'b1, $urandom);
		end
	endtask

	task automatic test_random_traffic(int total);
		int sent;
		sent = 0;
		while (sent < total) begin
			int kind;
			int len;
			kind = $urandom_range(0, 9);
			len = $urandom_range(5, 80);
			steady = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < len && sent < total; i++) begin
				logic [1:0] cmd;
				logic [DATA_W-1:0] val;
				int roll;
				roll = $urandom_range(0, 99);
				case (kind)
					0, 1, 2, 3: cmd = (roll < 85) ? CMD_PUSH : CMD_POP;
					4, 5, 6:    cmd = (roll < 85) ? CMD_POP : CMD_PUSH;
					7, 8:       cmd = (roll < 50) ? CMD_PUSH : CMD_POP;
					default: begin
						if (roll < 30) cmd = CMD_CLEAR;
						else if (roll < 50) cmd = CMD_UNUSED;
						else if (roll < 75) cmd = CMD_PUSH;
						else cmd = CMD_POP;
					end
				endcase
				case ($urandom_range(0, 7))
					0:       val = 32'h7FFF_FFFF;
					1:       val = 32'h8000_0000;
					2:       val = 32'hFFFF_FFFF;
					3:       val = 32'h0000_0000;
					default: val = $urandom;
				endcase
				send_request(cmd, 1'($urandom), val);
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		errors = 0;
		idle_cycles = 0;
		steady = 1'b0;
		lower_cnt = 0;
		upper_cnt = 0;
		foreach (stack_mem[i]) stack_mem[i] = '0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pops();
		test_extreme_values();
		test_unused_code();
		test_clear();
		test_fill_to_full();
		test_random_traffic(700);

		req_ch.valid <= 1'b0;
		while (stack_results_q.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/dss_pkg.sv
rtl/dss_chan_if.sv
rtl/dss_ctrl.sv
rtl/dss_dpath.sv
rtl/dual_stack_shared_array.sv
tb/sv/dual_stack_shared_array_tb.sv
